/* src/esq_pkg.sv */
`timescale 1ns / 1ps
// esq_pkg: shared types, gate and register codes, and reset values
// for the engine sample qualifier. No dependencies.
package esq_pkg;

    localparam int COUNT_BITS_DEFAULT = 32;
    localparam int GATE_COUNT         = 12;
    localparam int OUT_CNT_BITS       = 32;

    typedef enum logic [3:0] {
        GATE_ACC_ENR     = 4'd0,
        GATE_AFTER_START = 4'd1,
        GATE_LEARN       = 4'd2,
        GATE_TPS         = 4'd3,
        GATE_CLT         = 4'd4,
        GATE_RPM         = 4'd5,
        GATE_FUEL_CUT    = 4'd6,
        GATE_LAMBDA      = 4'd7,
        GATE_XMAX        = 4'd8,
        GATE_XMIN        = 4'd9,
        GATE_YMAX        = 4'd10,
        GATE_YMIN        = 4'd11
    } gate_t;

    typedef enum logic [1:0] {
        LEARN_NO_SYNC   = 2'd0,
        LEARN_TRANSIENT = 2'd1,
        LEARN_WARMUP    = 2'd2,
        LEARN_NOT_VALID = 2'd3
    } learn_cause_t;

    typedef enum logic [2:0] {
        REG_AFR_LOW  = 3'd0,
        REG_AFR_HIGH = 3'd1,
        REG_CLT_MIN  = 3'd2,
        REG_TPS_MAX  = 3'd3,
        REG_RPM_MIN  = 3'd4,
        REG_GATE_SEL = 3'd5,
        REG_X_LIMITS = 3'd6,
        REG_Y_LIMITS = 3'd7
    } cfg_reg_t;

    // presence bit positions
    localparam int PRES_AFR      = 0;
    localparam int PRES_COOLANT  = 1;
    localparam int PRES_ENGINE   = 2;
    localparam int PRES_PULSE    = 3;
    localparam int PRES_THROTTLE = 4;
    localparam int PRES_RPM      = 5;
    localparam int PRES_STATUS   = 6;
    localparam int PRES_X        = 7;
    localparam int PRES_Y        = 8;

    localparam int ENG_ASE_BIT   = 2;
    localparam int ENG_ACCEL_BIT = 4;

    localparam int STAT_SYNC_BIT      = 4;
    localparam int STAT_TRANSIENT_BIT = 5;
    localparam int STAT_WARMUP_BIT    = 6;
    localparam int STAT_VALID_BIT     = 7;

    localparam int SEL_LEARN_FIRST_BIT = 12;

    localparam logic [11:0] AFR_LOW_RESET  = 12'd700;
    localparam logic [11:0] AFR_HIGH_RESET = 12'd2500;
    localparam logic [11:0] CLT_MIN_RESET  = 12'd700;
    localparam logic [9:0]  TPS_MAX_RESET  = 10'd1000;
    localparam logic [13:0] RPM_MIN_RESET  = 14'd0;
    localparam logic [12:0] GATE_SEL_RESET = 13'd0;
    localparam logic [31:0] AXIS_RESET     = 32'h7FFF_8000;

    typedef struct packed {
        logic [11:0]        afr_low;
        logic [11:0]        afr_high;
        logic signed [11:0] clt_min;
        logic [9:0]         tps_max;
        logic [13:0]        rpm_min;
        logic [12:0]        gate_sel;
        logic [31:0]        x_limits;
        logic [31:0]        y_limits;
    } cfg_t;

    typedef struct packed {
        logic [11:0]        afr;
        logic signed [11:0] coolant;
        logic [7:0]         engine_status;
        logic [15:0]        pulse_width;
        logic [9:0]         throttle;
        logic [13:0]        rpm;
        logic [7:0]         status_a;
        logic signed [15:0] x_value;
        logic signed [15:0] y_value;
        logic [8:0]         channels_present;
    } item_t;

    typedef struct packed {
        logic         rejected;
        gate_t        gate;
        learn_cause_t cause;
    } verdict_t;

endpackage

/* src/esq_gates.sv */
`timescale 1ns / 1ps
// esq_gates: evaluates every gate on one record and picks the first rejecting
// gate: enabled gates by gate code, else the default list. Depends on esq_pkg.
module esq_gates
    import esq_pkg::*;
(
    input  item_t    item,
    input  cfg_t     cfg,
    output verdict_t verdict
);

    logic [GATE_COUNT-1:0] hit;
    logic [GATE_COUNT-1:0] enabled_hits;
    logic [GATE_COUNT-1:0] mask;
    logic [8:0]            pres;
    learn_cause_t          learn_cause;
    logic                  learn_first;
    logic                  rejected;
    gate_t                 gate;

    assign pres = item.channels_present;
    assign mask = cfg.gate_sel[GATE_COUNT-1:0];

    always_comb
    begin
        hit = '0;
        hit[GATE_LAMBDA]      = !pres[PRES_AFR] || (item.afr < cfg.afr_low)
                                || (item.afr > cfg.afr_high);
        hit[GATE_ACC_ENR]     = pres[PRES_ENGINE] && item.engine_status[ENG_ACCEL_BIT];
        hit[GATE_AFTER_START] = pres[PRES_ENGINE] && item.engine_status[ENG_ASE_BIT];
        hit[GATE_CLT]         = pres[PRES_COOLANT] && (item.coolant < cfg.clt_min);
        hit[GATE_FUEL_CUT]    = pres[PRES_PULSE] && (item.pulse_width == '0);
        hit[GATE_TPS]         = pres[PRES_THROTTLE] && (item.throttle > cfg.tps_max);
        hit[GATE_RPM]         = pres[PRES_RPM] && (item.rpm < cfg.rpm_min);
        hit[GATE_LEARN]       = pres[PRES_STATUS] && (!item.status_a[STAT_SYNC_BIT]
                                || item.status_a[STAT_TRANSIENT_BIT]
                                || item.status_a[STAT_WARMUP_BIT]
                                || !item.status_a[STAT_VALID_BIT]);
        hit[GATE_XMAX]    = pres[PRES_X] && (item.x_value > $signed(cfg.x_limits[31:16]));
        hit[GATE_XMIN]    = pres[PRES_X] && (item.x_value < $signed(cfg.x_limits[15:0]));
        hit[GATE_YMAX]    = pres[PRES_Y] && (item.y_value > $signed(cfg.y_limits[31:16]));
        hit[GATE_YMIN]    = pres[PRES_Y] && (item.y_value < $signed(cfg.y_limits[15:0]));
    end

    always_comb
    begin
        if (!item.status_a[STAT_SYNC_BIT])
            learn_cause = LEARN_NO_SYNC;
        else if (item.status_a[STAT_TRANSIENT_BIT])
            learn_cause = LEARN_TRANSIENT;
        else if (item.status_a[STAT_WARMUP_BIT])
            learn_cause = LEARN_WARMUP;
        else
            learn_cause = LEARN_NOT_VALID;
    end

    // learn gate jumps the queue only when it is not already in the list
    assign learn_first  = cfg.gate_sel[SEL_LEARN_FIRST_BIT]
                          && ((mask == '0) || !mask[GATE_LEARN]);
    assign enabled_hits = hit & mask;

    always_comb
    begin
        rejected = 1'b0;
        gate     = GATE_ACC_ENR;
        if (learn_first && hit[GATE_LEARN])
        begin
            rejected = 1'b1;
            gate     = GATE_LEARN;
        end
        else if (mask == '0)
        begin
            // default list: lambda, accel, after-start, coolant, overrun
            rejected = 1'b1;
            if (hit[GATE_LAMBDA])
                gate = GATE_LAMBDA;
            else if (hit[GATE_ACC_ENR])
                gate = GATE_ACC_ENR;
            else if (hit[GATE_AFTER_START])
                gate = GATE_AFTER_START;
            else if (hit[GATE_CLT])
                gate = GATE_CLT;
            else if (hit[GATE_FUEL_CUT])
                gate = GATE_FUEL_CUT;
            else
                rejected = 1'b0;
        end
        else
        begin
            rejected = |enabled_hits;
            for (int i = GATE_COUNT - 1; i >= 0; i--)
            begin
                if (enabled_hits[i])
                    gate = gate_t'(i[3:0]);
            end
        end
    end

    assign verdict.rejected = rejected;
    assign verdict.gate     = gate;
    assign verdict.cause    = (rejected && gate == GATE_LEARN) ? learn_cause : LEARN_NO_SYNC;

endmodule

/* src/esq_counters.sv */
`timescale 1ns / 1ps
// esq_counters: saturating record counters and per-gate rejection counters.
// Presents the updated values for the record being retired. Depends on esq_pkg.
module esq_counters
    import esq_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  verdict_t              verdict,
    output logic [COUNT_BITS-1:0] total_next,
    output logic [COUNT_BITS-1:0] accept_next,
    output logic [COUNT_BITS-1:0] reject_next,
    output logic [COUNT_BITS-1:0] gate_next
);

    logic [COUNT_BITS-1:0] total_reg;
    logic [COUNT_BITS-1:0] accept_reg;
    logic [COUNT_BITS-1:0] reject_reg;
    logic [COUNT_BITS-1:0] gate_cnt_reg [GATE_COUNT];

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
        return (&c) ? c : c + COUNT_BITS'(1);
    endfunction

    assign total_next  = sat_inc(total_reg);
    assign accept_next = verdict.rejected ? accept_reg : sat_inc(accept_reg);
    assign reject_next = verdict.rejected ? sat_inc(reject_reg) : reject_reg;
    assign gate_next   = sat_inc(gate_cnt_reg[verdict.gate]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg  <= '0;
            accept_reg <= '0;
            reject_reg <= '0;
            for (int i = 0; i < GATE_COUNT; i++)
                gate_cnt_reg[i] <= '0;
        end
        else if (advance)
        begin
            total_reg  <= total_next;
            accept_reg <= accept_next;
            reject_reg <= reject_next;
            for (int i = 0; i < GATE_COUNT; i++)
            begin
                if (verdict.rejected && verdict.gate == gate_t'(i[3:0]))
                    gate_cnt_reg[i] <= gate_next;
            end
        end
    end

endmodule

/* src/engine_sample_qualifier.sv */
`timescale 1ns / 1ps
// engine_sample_qualifier: top level. Config registers, input stage, result stage.
// Depends on esq_pkg, esq_gates, esq_counters.
//
// Usage:
//   Input channel in_valid/in_ready carries one engine log record per transfer.
//   Output channel out_valid/out_ready carries one verdict per record: accepted,
//   rejecting gate, learn cause and the counters as they stand after the record.
//   Configuration: cfg_write with cfg_index/cfg_data writes one register at the
//   clock edge; write only while no record is in flight.
//   Path: a transferred record moves through the input register and then the
//   result register (two register stages) before its result is valid.
//   Throughput: one record per cycle while out_ready is high. Gate checks and counter
//   updates sit in one combinational stage between the input and result registers.
//   Stall: when out_ready is low with a result waiting, the input register
//   still takes one more record; after that in_ready drops until the result
//   is taken. Counters advance only when a record moves into the result register.
//   Reset: clears both valid flags, all counters, and returns the config
//   registers to their defaults (open axis limits, default gate list).
module engine_sample_qualifier
    import esq_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,

    input  logic               in_valid,
    output logic               in_ready,
    input  logic [11:0]        afr,
    input  logic signed [11:0] coolant,
    input  logic [7:0]         engine_status,
    input  logic [15:0]        pulse_width,
    input  logic [9:0]         throttle,
    input  logic [13:0]        rpm,
    input  logic [7:0]         status_a,
    input  logic signed [15:0] x_value,
    input  logic signed [15:0] y_value,
    input  logic [8:0]         channels_present,

    output logic               out_valid,
    input  logic               out_ready,
    output logic               accepted,
    output logic [3:0]         reject_gate,
    output logic [1:0]         learn_reason,
    output logic [31:0]        total_seen,
    output logic [31:0]        accepted_seen,
    output logic [31:0]        rejected_seen,
    output logic [31:0]        gate_reject_total
);

    cfg_t     cfg_reg;
    item_t    item_reg;
    logic     item_valid_reg;
    logic     out_valid_reg;
    logic     out_free;
    logic     in_xfer;
    logic     advance;
    verdict_t verdict;

    logic [COUNT_BITS-1:0] total_next;
    logic [COUNT_BITS-1:0] accept_next;
    logic [COUNT_BITS-1:0] reject_next;
    logic [COUNT_BITS-1:0] gate_next;

    // zero-extend before taking the low word so any counter width works
    logic [COUNT_BITS+OUT_CNT_BITS-1:0] total_ext;
    logic [COUNT_BITS+OUT_CNT_BITS-1:0] accept_ext;
    logic [COUNT_BITS+OUT_CNT_BITS-1:0] reject_ext;
    logic [COUNT_BITS+OUT_CNT_BITS-1:0] gate_ext;

    logic         accepted_reg;
    gate_t        reject_gate_reg;
    learn_cause_t learn_reason_reg;
    logic [31:0]  total_seen_reg;
    logic [31:0]  accepted_seen_reg;
    logic [31:0]  rejected_seen_reg;
    logic [31:0]  gate_reject_total_reg;

    assign out_free = !out_valid_reg || out_ready;
    assign advance  = item_valid_reg && out_free;
    assign in_ready = !item_valid_reg || out_free;
    assign in_xfer  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.afr_low  <= AFR_LOW_RESET;
            cfg_reg.afr_high <= AFR_HIGH_RESET;
            cfg_reg.clt_min  <= CLT_MIN_RESET;
            cfg_reg.tps_max  <= TPS_MAX_RESET;
            cfg_reg.rpm_min  <= RPM_MIN_RESET;
            cfg_reg.gate_sel <= GATE_SEL_RESET;
            cfg_reg.x_limits <= AXIS_RESET;
            cfg_reg.y_limits <= AXIS_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_AFR_LOW:  cfg_reg.afr_low  <= cfg_data[11:0];
                REG_AFR_HIGH: cfg_reg.afr_high <= cfg_data[11:0];
                REG_CLT_MIN:  cfg_reg.clt_min  <= cfg_data[11:0];
                REG_TPS_MAX:  cfg_reg.tps_max  <= cfg_data[9:0];
                REG_RPM_MIN:  cfg_reg.rpm_min  <= cfg_data[13:0];
                REG_GATE_SEL: cfg_reg.gate_sel <= cfg_data[12:0];
                REG_X_LIMITS: cfg_reg.x_limits <= cfg_data;
                REG_Y_LIMITS: cfg_reg.y_limits <= cfg_data;
                default: ;
            endcase
        end
    end

    // input stage: payload needs no reset
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            item_reg.afr              <= afr;
            item_reg.coolant          <= coolant;
            item_reg.engine_status    <= engine_status;
            item_reg.pulse_width      <= pulse_width;
            item_reg.throttle         <= throttle;
            item_reg.rpm              <= rpm;
            item_reg.status_a         <= status_a;
            item_reg.x_value          <= x_value;
            item_reg.y_value          <= y_value;
            item_reg.channels_present <= channels_present;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (in_xfer)
            item_valid_reg <= 1'b1;
        else if (advance)
            item_valid_reg <= 1'b0;
    end

    esq_gates u_gates (
        .item    (item_reg),
        .cfg     (cfg_reg),
        .verdict (verdict)
    );

    esq_counters #(
        .COUNT_BITS (COUNT_BITS)
    ) u_counters (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .verdict     (verdict),
        .total_next  (total_next),
        .accept_next (accept_next),
        .reject_next (reject_next),
        .gate_next   (gate_next)
    );

    assign total_ext  = {{OUT_CNT_BITS{1'b0}}, total_next};
    assign accept_ext = {{OUT_CNT_BITS{1'b0}}, accept_next};
    assign reject_ext = {{OUT_CNT_BITS{1'b0}}, reject_next};
    assign gate_ext   = {{OUT_CNT_BITS{1'b0}}, gate_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            accepted_reg          <= !verdict.rejected;
            reject_gate_reg       <= verdict.rejected ? verdict.gate : GATE_ACC_ENR;
            learn_reason_reg      <= verdict.cause;
            total_seen_reg        <= total_ext[OUT_CNT_BITS-1:0];
            accepted_seen_reg     <= accept_ext[OUT_CNT_BITS-1:0];
            rejected_seen_reg     <= reject_ext[OUT_CNT_BITS-1:0];
            gate_reject_total_reg <= verdict.rejected ? gate_ext[OUT_CNT_BITS-1:0] : '0;
        end
    end

    assign out_valid         = out_valid_reg;
    assign accepted          = accepted_reg;
    assign reject_gate       = reject_gate_reg;
    assign learn_reason      = learn_reason_reg;
    assign total_seen        = total_seen_reg;
    assign accepted_seen     = accepted_seen_reg;
    assign rejected_seen     = rejected_seen_reg;
    assign gate_reject_total = gate_reject_total_reg;

`ifndef SYNTHESIS
    a_accept_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && accepted |->
            reject_gate == GATE_ACC_ENR && learn_reason == LEARN_NO_SYNC
            && gate_reject_total == '0)
        else $error("accepted record carries rejection data");

    a_reason_learn_only: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && reject_gate != GATE_LEARN |-> learn_reason == LEARN_NO_SYNC)
        else $error("learn cause set for a non-learn gate");

    a_reject_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !accepted |-> gate_reject_total != '0)
        else $error("rejecting gate count not advanced");

    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg && !out_free |=> item_valid_reg && $stable(item_reg))
        else $error("input stage lost a record during stall");
`endif

endmodule
